### rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
    localparam int unsigned FieldWidthDefault = 32;
    localparam int unsigned InWidth = 32;
    localparam int unsigned ProdWidth = 64;
    localparam int unsigned SumWidth = 65;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CMP  = 3'd4,
        OP_ABS  = 3'd5,
        OP_NORM = 3'd6,
        OP_NOP  = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        t_op         op;
        logic        zden;
        logic        an_neg;
        logic [31:0] an_mag;
        logic        ad_neg;
        logic [31:0] ad_mag;
        logic        bn_neg;
        logic [31:0] bn_mag;
        logic        bd_neg;
        logic [31:0] bd_mag;
    } t_cmd;
endpackage

### rtl/rau_if.sv
`timescale 1ns / 1ps
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic signed [1:0] order;
    logic [1:0]  status;
    modport source (output valid, res_num, res_den, order, status, input ready);
    modport sink (input valid, res_num, res_den, order, status, output ready);
endinterface

### rtl/rau_front.sv
`timescale 1ns / 1ps
module rau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rau_in_if.sink         i_req,
    output logic           o_valid,
    output rau_pkg::t_cmd  o_cmd,
    input  logic           i_ready
);
    logic [1:0]    r_cnt;
    logic          r_wp;
    logic          r_rp;
    rau_pkg::t_cmd r_q [rau_pkg::QueueDepth];
    rau_pkg::t_cmd n_cmd;
    logic          w_push;
    logic          w_pop;
    logic          w_ub;

    // sign and magnitude of one field
    function automatic logic [32:0] smag(input logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return {v[31], m};
    endfunction

    // classify the request
    always_comb begin
        n_cmd.op = rau_pkg::t_op'(i_req.op);
        {n_cmd.an_neg, n_cmd.an_mag} = smag(i_req.a_num);
        {n_cmd.ad_neg, n_cmd.ad_mag} = smag(i_req.a_den);
        {n_cmd.bn_neg, n_cmd.bn_mag} = smag(i_req.b_num);
        {n_cmd.bd_neg, n_cmd.bd_mag} = smag(i_req.b_den);
        w_ub = (n_cmd.op <= rau_pkg::OP_CMP);
        n_cmd.zden = (n_cmd.op != rau_pkg::OP_NOP) &&
            ((n_cmd.ad_mag == '0) || (w_ub && n_cmd.bd_mag == '0) ||
             (n_cmd.op == rau_pkg::OP_DIV && n_cmd.bn_mag == '0));
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push = i_req.valid && i_req.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop = o_valid && i_ready;
    assign o_cmd = r_q[r_rp];

    // request queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wp] <= n_cmd;
    end
endmodule

### rtl/rau_back.sv
`timescale 1ns / 1ps
module rau_back #(
    parameter int unsigned FIELD_WIDTH = rau_pkg::FieldWidthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rau_pkg::t_cmd  i_cmd,
    output logic           o_ready,
    rau_out_if.source      o_res
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_OUT} t_state;
    localparam int unsigned PW = rau_pkg::ProdWidth;
    localparam int unsigned CW = $clog2(PW + 1);
    localparam logic [PW-1:0] Lim = PW'(1) << (FIELD_WIDTH - 1);

    t_state          r_state;
    rau_pkg::t_cmd   r_cmd;
    logic            r_p_neg, r_q_neg, r_n_neg, r_d_neg;
    logic [PW-1:0]   r_p, r_q, r_d, r_n;
    logic [PW-1:0]   r_x, r_y;
    logic [PW-1:0]   r_rem, r_quo, r_dvd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   r_nm;
    logic            r_first;
    logic signed [31:0] r_res_num;
    logic [30:0]     r_res_den;
    logic signed [1:0] r_order;
    logic [1:0]      r_status;
    logic signed [31:0] r_out_num;
    logic [30:0]     r_out_den;
    logic signed [1:0] r_out_order;
    logic [1:0]      r_out_status;
    logic            r_ovalid;
    logic [PW:0]     w_trial;
    logic [PW-1:0]   w_rem_sh;
    logic [PW-1:0]   w_dvs;
    logic            w_neg;

    // 32 by 32 unsigned product at full width
    function automatic logic [PW-1:0] umul(input logic [31:0] a, input logic [31:0] b);
        return PW'(a) * PW'(b);
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.res_num = r_out_num;
    assign o_res.res_den = r_out_den;
    assign o_res.order = r_out_order;
    assign o_res.status = r_out_status;

    // restoring divider step, shared by gcd and the final divides
    assign w_dvs = (r_state == S_GCD) ? r_y : r_x;
    assign w_rem_sh = {r_rem[PW-2:0], r_dvd[PW-1]};
    assign w_trial = {1'b0, w_rem_sh} - {1'b0, w_dvs};
    assign w_neg = r_n_neg != r_d_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_state <= S_MUL;
                    end
                end
                // products of the fields, or the plain fields for abs and normalize
                S_MUL: begin
                    r_res_num <= '0;
                    r_res_den <= 31'd1;
                    r_order <= '0;
                    r_status <= rau_pkg::ST_OK;
                    unique case (r_cmd.op)
                        rau_pkg::OP_MUL: begin
                            r_p <= umul(r_cmd.an_mag, r_cmd.bn_mag);
                            r_p_neg <= r_cmd.an_neg ^ r_cmd.bn_neg;
                            r_q <= umul(r_cmd.ad_mag, r_cmd.bd_mag);
                            r_q_neg <= r_cmd.ad_neg ^ r_cmd.bd_neg;
                        end
                        rau_pkg::OP_DIV: begin
                            r_p <= umul(r_cmd.an_mag, r_cmd.bd_mag);
                            r_p_neg <= r_cmd.an_neg ^ r_cmd.bd_neg;
                            r_q <= umul(r_cmd.ad_mag, r_cmd.bn_mag);
                            r_q_neg <= r_cmd.ad_neg ^ r_cmd.bn_neg;
                        end
                        rau_pkg::OP_ABS, rau_pkg::OP_NORM: begin
                            r_p <= PW'(r_cmd.an_mag);
                            r_p_neg <= r_cmd.an_neg && (r_cmd.op == rau_pkg::OP_NORM);
                            r_q <= PW'(r_cmd.ad_mag);
                            r_q_neg <= r_cmd.ad_neg && (r_cmd.op == rau_pkg::OP_NORM);
                        end
                        default: begin
                            r_p <= umul(r_cmd.an_mag, r_cmd.bd_mag);
                            r_p_neg <= r_cmd.an_neg ^ r_cmd.bd_neg;
                            r_q <= umul(r_cmd.bn_mag, r_cmd.ad_mag);
                            r_q_neg <= r_cmd.bn_neg ^ r_cmd.ad_neg ^
                                (r_cmd.op != rau_pkg::OP_ADD);
                        end
                    endcase
                    r_d <= umul(r_cmd.ad_mag, r_cmd.bd_mag);
                    r_d_neg <= r_cmd.ad_neg ^ r_cmd.bd_neg;
                    if (r_cmd.zden || r_cmd.op == rau_pkg::OP_NOP) begin
                        if (r_cmd.zden) r_status <= rau_pkg::ST_ZDEN;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                // signed sum, or pick the operands of mul, div, abs, normalize
                S_SUM: begin
                    if (r_cmd.op == rau_pkg::OP_ADD || r_cmd.op == rau_pkg::OP_SUB ||
                        r_cmd.op == rau_pkg::OP_CMP) begin
                        // magnitudes below 2^63, sum fits
                        if (r_p_neg == r_q_neg) begin
                            r_n <= r_p + r_q;
                            r_n_neg <= r_p_neg;
                        end else if (r_p >= r_q) begin
                            r_n <= r_p - r_q;
                            r_n_neg <= r_p_neg;
                        end else begin
                            r_n <= r_q - r_p;
                            r_n_neg <= r_q_neg;
                        end
                    end else begin
                        r_n <= r_p;
                        r_n_neg <= r_p_neg;
                        r_d <= r_q;
                        r_d_neg <= r_q_neg;
                    end
                    r_first <= 1'b1;
                    r_state <= S_GCD;
                end
                // euclid: x mod y by bit-serial division
                S_GCD: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        if (r_cmd.op == rau_pkg::OP_CMP) begin
                            if (r_n != '0)
                                r_order <= (r_n_neg != r_d_neg) ? -2'sd1 : 2'sd1;
                            r_state <= S_OUT;
                        end else if (r_n == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_x <= r_n;
                            r_y <= r_d;
                            r_rem <= '0;
                            r_dvd <= r_n;
                            r_cnt <= CW'(PW);
                        end
                    end else if (r_y == '0) begin
                        // gcd in r_x, divide numerator
                        r_rem <= '0;
                        r_dvd <= r_n;
                        r_cnt <= CW'(PW);
                        r_state <= S_DIVN;
                    end else if (r_cnt != '0) begin
                        r_rem <= w_trial[PW] ? w_rem_sh : w_trial[PW-1:0];
                        r_dvd <= {r_dvd[PW-2:0], 1'b0};
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_x <= r_y;
                        r_y <= r_rem;
                        r_rem <= '0;
                        r_dvd <= r_y;
                        r_cnt <= CW'(PW);
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (r_cnt != '0) begin
                        r_rem <= w_trial[PW] ? w_rem_sh : w_trial[PW-1:0];
                        r_dvd <= {r_dvd[PW-2:0], 1'b0};
                        r_quo <= {r_quo[PW-2:0], ~w_trial[PW]};
                        r_cnt <= r_cnt - CW'(1);
                    end else if (r_state == S_DIVN) begin
                        r_nm <= r_quo;
                        r_rem <= '0;
                        r_dvd <= r_d;
                        r_cnt <= CW'(PW);
                        r_state <= S_DIVD;
                    end else begin
                        // range check and sign to numerator
                        if (r_quo > Lim - PW'(1) ||
                            (w_neg ? (r_nm > Lim) : (r_nm > Lim - PW'(1)))) begin
                            r_status <= rau_pkg::ST_OVF;
                        end else begin
                            r_res_num <= w_neg ? (~r_nm[31:0] + 32'd1) : r_nm[31:0];
                            r_res_den <= r_quo[30:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                // hand the result to the output register once it is free
                S_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_out_num <= r_res_num;
                        r_out_den <= r_res_den;
                        r_out_order <= r_order;
                        r_out_status <= r_status;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// channel   direction  fields
// i_req     in         op, a_num, a_den, b_num, b_den
// o_res     out        res_num, res_den, order, status
// a zero denominator or nop goes from the product state straight to the output,
// compare or a zero numerator ends at the first gcd step, else euclid steps run
// on the one-bit-per-cycle divider and two divides by the gcd reduce the fraction
// synchronous active-low reset empties the two-entry request queue
// the front keeps taking requests while the back works or its result waits
module rational_arithmetic_unit_top #(
    parameter int unsigned FIELD_WIDTH = rau_pkg::FieldWidthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_req,
    rau_out_if.source o_res
);
    logic          w_valid;
    logic          w_ready;
    rau_pkg::t_cmd w_cmd;

    rau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (w_valid),
        .o_cmd   (w_cmd),
        .i_ready (w_ready)
    );

    rau_back #(.FIELD_WIDTH(FIELD_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_cmd   (w_cmd),
        .o_ready (w_ready),
        .o_res   (o_res)
    );
endmodule

### verif/tb_rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit_top;
    localparam int unsigned FW = 32;
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] NEG1 = 32'hFFFF_FFFF;

    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } t_smag;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic signed [1:0]  ord;
        logic [1:0]         st;
    } t_frac_result;

    // fraction predictor and store of expected results
    class frac_scoreboard;
        t_frac_result pending[$];
        int unsigned  errors;

        function new();
            errors = 0;
        endfunction

        function t_smag split(logic [31:0] raw);
            t_smag r;
            r.neg = raw[31];
            r.mag = {32'd0, raw[31] ? (~raw + 32'd1) : raw};
            return r;
        endfunction

        function t_smag mul_sm(t_smag x, t_smag y);
            t_smag r;
            r.mag = x.mag * y.mag;
            r.neg = (r.mag != 0) && (x.neg != y.neg);
            return r;
        endfunction

        function t_smag add_sm(t_smag x, t_smag y);
            t_smag r;
            if (x.neg == y.neg) begin
                r.mag = x.mag + y.mag;
                r.neg = x.neg;
            end else if (x.mag >= y.mag) begin
                r.mag = x.mag - y.mag;
                r.neg = x.neg;
            end else begin
                r.mag = y.mag - x.mag;
                r.neg = y.neg;
            end
            if (r.mag == 0) r.neg = 0;
            return r;
        endfunction

        function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
            logic [63:0] t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // reduce n/d, sign to numerator, range check
        function void reduce_frac(t_smag n, t_smag d, ref t_frac_result r);
            logic [63:0] g, nm, dm, lim;
            bit neg;
            r.num = 0;
            r.den = 1;
            r.st  = rau_pkg::ST_OK;
            if (n.mag == 0) return;
            g   = gcd64(n.mag, d.mag);
            nm  = n.mag / g;
            dm  = d.mag / g;
            neg = n.neg != d.neg;
            lim = 64'd1 << (FW - 1);
            if (dm > lim - 1 || (neg ? (nm > lim) : (nm > lim - 1))) begin
                r.st = rau_pkg::ST_OVF;
                return;
            end
            r.num = neg ? (~nm[31:0] + 32'd1) : nm[31:0];
            r.den = dm[30:0];
        endfunction

        function void note_request(rau_pkg::t_op op, logic [31:0] an_raw,
                                   logic [31:0] ad_raw, logic [31:0] bn_raw,
                                   logic [31:0] bd_raw);
            t_smag an, ad, bn, bd, p, q, n;
            t_frac_result r;
            bit uses_b;
            an = split(an_raw);
            ad = split(ad_raw);
            bn = split(bn_raw);
            bd = split(bd_raw);
            r.num = 0;
            r.den = 1;
            r.ord = 0;
            r.st  = rau_pkg::ST_OK;
            uses_b = (op <= rau_pkg::OP_CMP);
            if (op == rau_pkg::OP_NOP) begin
                // nothing to do
            end else if (ad.mag == 0 || (uses_b && bd.mag == 0) ||
                         (op == rau_pkg::OP_DIV && bn.mag == 0)) begin
                r.st = rau_pkg::ST_ZDEN;
            end else begin
                case (op)
                    rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                        p = mul_sm(an, bd);
                        q = mul_sm(bn, ad);
                        if (op == rau_pkg::OP_SUB && q.mag != 0) q.neg = !q.neg;
                        reduce_frac(add_sm(p, q), mul_sm(ad, bd), r);
                    end
                    rau_pkg::OP_MUL: reduce_frac(mul_sm(an, bn), mul_sm(ad, bd), r);
                    rau_pkg::OP_DIV: reduce_frac(mul_sm(an, bd), mul_sm(ad, bn), r);
                    rau_pkg::OP_CMP: begin
                        q = mul_sm(bn, ad);
                        if (q.mag != 0) q.neg = !q.neg;
                        n = add_sm(mul_sm(an, bd), q);
                        if (n.mag != 0)
                            r.ord = (n.neg != (ad.neg != bd.neg)) ? -2'sd1 : 2'sd1;
                    end
                    rau_pkg::OP_ABS: begin
                        an.neg = 0;
                        ad.neg = 0;
                        reduce_frac(an, ad, r);
                    end
                    default: reduce_frac(an, ad, r);
                endcase
            end
            if (r.st != rau_pkg::ST_OK) begin
                r.num = 0;
                r.den = 1;
            end
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_frac_result got);
            t_frac_result exp_r;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            exp_r = pending.pop_front();
            if (got.num !== exp_r.num)
                report($sformatf("res_num got %0d exp %0d", got.num, exp_r.num));
            if (got.den !== exp_r.den)
                report($sformatf("res_den got %0d exp %0d", got.den, exp_r.den));
            if (got.ord !== exp_r.ord)
                report($sformatf("order got %0d exp %0d", got.ord, exp_r.ord));
            if (got.st !== exp_r.st)
                report($sformatf("status got %0d exp %0d", got.st, exp_r.st));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    rau_in_if  req_if ();
    rau_out_if res_if ();

    frac_scoreboard sb;
    bit          steady;
    int unsigned accepted;
    longint unsigned cycles;

    rational_arithmetic_unit_top #(.FIELD_WIDTH(FW)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.source),
        .o_res  (res_if.sink)
    );

    // clock
    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // timeout guard
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // monitor, sampled mid-cycle so values are stable before the edge
    always @(negedge i_clk) begin
        t_frac_result got;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            sb.note_request(rau_pkg::t_op'(req_if.op), req_if.a_num, req_if.a_den,
                            req_if.b_num, req_if.b_den);
            accepted++;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.num = res_if.res_num;
            got.den = res_if.res_den;
            got.ord = res_if.order;
            got.st  = res_if.status;
            sb.check_result(got);
        end
    end

    // result side ready, with one long hold-off to back the block up
    initial begin
        int unsigned hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        res_if.ready = 0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && accepted >= 100) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 0;
            end else begin
                res_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 32);
            end
        end
    end

    task send_req(rau_pkg::t_op op, logic [31:0] an, logic [31:0] ad, logic [31:0] bn,
                  logic [31:0] bd);
        bit done;
        while (!steady && $urandom_range(99) < 32) begin
            req_if.valid <= 0;
            @(posedge i_clk);
        end
        req_if.valid <= 1;
        req_if.op    <= op;
        req_if.a_num <= an;
        req_if.a_den <= ad;
        req_if.b_num <= bn;
        req_if.b_den <= bd;
        do begin
            @(negedge i_clk);
            done = req_if.valid && req_if.ready;
            @(posedge i_clk);
        end while (!done);
    endtask

    // operand mix: mostly small values to keep gcd runs short
    function logic [31:0] rand_operand();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) return 32'($signed($urandom_range(200)) - 100);
        if (pick < 70) return {{16{1'b0}}, 16'($urandom)} - 32'd32768;
        if (pick < 80) begin
            case ($urandom_range(4))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFF;
                3: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        sb = new();
        steady = 0;
        accepted = 0;
        i_rst_n = 0;
        req_if.valid = 0;
        req_if.op = rau_pkg::OP_ADD;
        req_if.a_num = 0;
        req_if.a_den = 1;
        req_if.b_num = 0;
        req_if.b_den = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every op, special cases
        send_req(rau_pkg::OP_ADD, MAXV, 1, MAXV, 1);
        send_req(rau_pkg::OP_ADD, MINV, 1, MINV, 1);
        send_req(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_req(rau_pkg::OP_SUB, 5, 7, 5, 7);
        send_req(rau_pkg::OP_SUB, MINV, MAXV, MAXV, MINV);
        send_req(rau_pkg::OP_MUL, MAXV, 3, MAXV, 5);
        send_req(rau_pkg::OP_MUL, -32'sd6, 4, 2, -32'sd9);
        send_req(rau_pkg::OP_DIV, 3, 4, 0, 5);
        send_req(rau_pkg::OP_DIV, MINV, 1, NEG1, 1);
        send_req(rau_pkg::OP_DIV, 7, -32'sd3, 14, 9);
        send_req(rau_pkg::OP_CMP, 1, -32'sd2, 1, 3);
        send_req(rau_pkg::OP_CMP, 2, 4, 1, 2);
        send_req(rau_pkg::OP_CMP, MINV, NEG1, MAXV, MINV);
        send_req(rau_pkg::OP_CMP, 1, 0, 1, 1);
        send_req(rau_pkg::OP_ADD, 1, 1, 1, 0);
        send_req(rau_pkg::OP_ABS, MINV, 1, 0, 0);
        send_req(rau_pkg::OP_ABS, -32'sd9, -32'sd6, 0, 0);
        send_req(rau_pkg::OP_ABS, 0, -32'sd5, 0, 0);
        send_req(rau_pkg::OP_NORM, MINV, NEG1, 0, 0);
        send_req(rau_pkg::OP_NORM, 6, -32'sd4, 0, 0);
        send_req(rau_pkg::OP_NORM, MINV, MINV, 0, 0);
        send_req(rau_pkg::OP_NORM, 5, 0, 0, 0);
        send_req(rau_pkg::OP_NOP, MAXV, 0, MINV, 0);

        // random, with a calm stretch in the middle
        for (int i = 0; i < 750; i++) begin
            steady = (i >= 300 && i < 450);
            send_req(rau_pkg::t_op'($urandom_range(7)), rand_operand(), rand_operand(),
                     rand_operand(), rand_operand());
        end
        steady = 0;
        req_if.valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.pending.size() != 0) sb.report("expected results left over");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_front.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit_top.sv
verif/tb_rational_arithmetic_unit_top.sv
